// ===== rtl/core/paged_byte_memory_access_core_assert.svh =====
// Assertion macros for the paged byte memory access core.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef PAGED_BYTE_MEMORY_ACCESS_CORE_ASSERT_SVH
`define PAGED_BYTE_MEMORY_ACCESS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PBMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PBMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pbma_pkg.sv =====
// Package for the paged byte memory access core: sequencer states, status codes.
// No dependencies.
`timescale 1ns / 1ps

package pbma_pkg;

    // Largest number of bytes in one transaction
    localparam int MaxBytes = 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_LEN = 2'd1,
        ST_RANGE    = 2'd2,
        ST_UNALLOC  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

// ===== rtl/core/paged_byte_memory_access_core.sv =====
// Paged byte memory access core: one byte-wide store, page allocation flags and the
// byte sequencer. Depends on pbma_pkg and paged_byte_memory_access_core_assert.svh.
`timescale 1ns / 1ps

// After reset the core sweeps the byte store to zero, one byte a cycle, over all
// 2^(SET_BITS+MID_BITS+LOW_BITS) bytes (65536 at the defaults) with busy high.
// A transaction is taken when start is high and busy is low. The single-port byte
// memory moves one byte per cycle, so an accepted read keeps busy high while it
// issues its n byte reads, collects the last registered read byte and shows the
// result; an accepted write while it writes its n bytes and shows the result; a
// rejected length or range goes to the result. The result is shown for exactly one
// cycle with done high and cannot be held off: the receiver must take it then.
module paged_byte_memory_access_core #(
    parameter int SET_BITS = 8,
    parameter int MID_BITS = 0,
    parameter int LOW_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [15:0] byte_addr,
    input  logic [3:0]  byte_count,
    input  logic [63:0] write_value,
    output logic        done,
    output logic [63:0] read_value,
    output logic [1:0]  status
);

`include "paged_byte_memory_access_core_assert.svh"

    localparam int ADDR_BITS  = SET_BITS + MID_BITS + LOW_BITS;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;
    localparam int PG_BITS    = SET_BITS + MID_BITS;
    localparam int PAGE_COUNT = 1 << PG_BITS;
    localparam int PG_W       = (PG_BITS > 0) ? PG_BITS : 1;
    localparam int SUM_W      = (ADDR_BITS > 16) ? ADDR_BITS + 1 : 17;
    localparam logic [SUM_W-1:0] SPACE_LIM = {{(SUM_W-1){1'b0}}, 1'b1} << ADDR_BITS;

    // Byte store and page flags
    logic [7:0]           mem [MEM_DEPTH];
    logic [7:0]           mem_q_reg;
    logic                 page_alloc_reg [PAGE_COUNT];

    pbma_pkg::state_t     state_reg, state_next;
    pbma_pkg::status_t    status_reg, status_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [2:0]           idx_reg, idx_next;
    logic [2:0]           lane_reg, lane_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 ok_reg, ok_next;
    logic                 cmd_reg, cmd_next;
    logic [63:0]          wdata_reg, wdata_next;
    logic [63:0]          rdata_reg, rdata_next;

    logic                 mem_we;
    logic [7:0]           mem_wdata;
    logic [PG_W-1:0]      page_idx;
    logic                 page_set;
    logic [SUM_W-1:0]     end_sum;
    logic                 range_bad;
    logic                 last_byte;
    logic [63:0]          merged;

    assign page_idx  = PG_W'(addr_reg >> LOW_BITS);
    assign end_sum   = SUM_W'(byte_addr) + SUM_W'(byte_count);
    assign range_bad = (byte_count > 4'(pbma_pkg::MaxBytes)) || (end_sum > SPACE_LIM);
    assign last_byte = ((4'(idx_reg) + 4'd1) == cnt_reg);

    // Fold the byte read in the previous cycle into the assembled value
    always_comb
    begin
        merged = rdata_reg;
        if (rd_pend_reg)
        begin
            merged[{lane_reg, 3'b000} +: 8] = mem_q_reg;
        end
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        lane_next    = idx_reg;
        rd_pend_next = 1'b0;
        ok_next      = ok_reg;
        cmd_next     = cmd_reg;
        wdata_next   = wdata_reg;
        rdata_next   = merged;
        mem_we       = 1'b0;
        mem_wdata    = 8'd0;
        page_set     = 1'b0;

        unique case (state_reg)
            pbma_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == '1)
                begin
                    state_next = pbma_pkg::S_IDLE;
                end
            end
            pbma_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    addr_next  = ADDR_BITS'(byte_addr);
                    cnt_next   = byte_count;
                    idx_next   = 3'd0;
                    ok_next    = 1'b1;
                    wdata_next = write_value;
                    rdata_next = 64'd0;
                    priority if (byte_count == 4'd0)
                    begin
                        status_next = pbma_pkg::ST_ZERO_LEN;
                        state_next  = pbma_pkg::S_RESP;
                    end
                    else if (range_bad)
                    begin
                        status_next = pbma_pkg::ST_RANGE;
                        state_next  = pbma_pkg::S_RESP;
                    end
                    else
                    begin
                        status_next = pbma_pkg::ST_OK;
                        state_next  = cmd ? pbma_pkg::S_WRITE : pbma_pkg::S_READ;
                    end
                end
            end
            pbma_pkg::S_READ:
            begin
                // Issue one byte read and check its page
                rd_pend_next = 1'b1;
                ok_next      = ok_reg & page_alloc_reg[page_idx];
                addr_next    = addr_reg + 1'b1;
                idx_next     = idx_reg + 3'd1;
                if (last_byte)
                begin
                    state_next = pbma_pkg::S_DRAIN;
                end
            end
            pbma_pkg::S_DRAIN:
            begin
                // Last byte arrives; drop the value on an unallocated page
                if (!ok_reg)
                begin
                    status_next = pbma_pkg::ST_UNALLOC;
                    rdata_next  = 64'd0;
                end
                state_next = pbma_pkg::S_RESP;
            end
            pbma_pkg::S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = wdata_reg[{idx_reg, 3'b000} +: 8];
                page_set  = 1'b1;
                addr_next = addr_reg + 1'b1;
                idx_next  = idx_reg + 3'd1;
                if (last_byte)
                begin
                    state_next = pbma_pkg::S_RESP;
                end
            end
            pbma_pkg::S_RESP:
            begin
                state_next = pbma_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pbma_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pbma_pkg::S_CLEAR;
            status_reg  <= pbma_pkg::ST_OK;
            addr_reg    <= '0;
            cnt_reg     <= 4'd0;
            idx_reg     <= 3'd0;
            lane_reg    <= 3'd0;
            rd_pend_reg <= 1'b0;
            ok_reg      <= 1'b0;
            cmd_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            addr_reg    <= addr_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            lane_reg    <= lane_next;
            rd_pend_reg <= rd_pend_next;
            ok_reg      <= ok_next;
            cmd_reg     <= cmd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wdata_reg <= wdata_next;
        rdata_reg <= rdata_next;
    end

    // Page allocation flags: cleared at reset, set by each written byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                page_alloc_reg[i] <= 1'b0;
            end
        end
        else if (page_set)
        begin
            page_alloc_reg[page_idx] <= 1'b1;
        end
    end

    // Byte store: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        mem_q_reg <= mem[addr_reg];
    end

    // Outputs
    assign busy       = (state_reg != pbma_pkg::S_IDLE);
    assign done       = (state_reg == pbma_pkg::S_RESP);
    assign read_value = rdata_reg;
    assign status     = status_reg;

    // Checks
    `PBMA_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
        "accepted transaction did not raise busy")
    `PBMA_ASSERT_NEXT(a_done_single, done, !done, "result shown for more than one cycle")
    `PBMA_ASSERT_NOW(a_unalloc_zero, done && (status == pbma_pkg::ST_UNALLOC),
        read_value == 64'd0, "unallocated read returned data")
    `PBMA_ASSERT_NOW(a_write_result, done && cmd_reg,
        (read_value == 64'd0) && (status != pbma_pkg::ST_UNALLOC),
        "write returned data or page error")
    `PBMA_ASSERT_NOW(a_idx_bound,
        (state_reg == pbma_pkg::S_WRITE) || (state_reg == pbma_pkg::S_READ),
        4'(idx_reg) < cnt_reg, "byte index ran past the length")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for paged_byte_memory_access_core: directed and random byte accesses,
// checked against an in-bench byte image and page table. Depends on pbma_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int PageShift   = 8;
    localparam int SpaceSize   = 65536;
    localparam int PageCount   = 256;
    localparam bit CMD_READ    = 1'b0;
    localparam bit CMD_WRITE   = 1'b1;
    localparam int NumRandom   = 1625;
    localparam int NumHot      = 12;
    localparam int CalmTail    = 250;
    localparam int DrainCycles = 16;

    typedef struct {
        bit        cmd;
        bit [15:0] addr;
        bit [3:0]  count;
        bit [63:0] wdata;
    } access_t;

    typedef struct {
        bit [63:0]         rdata;
        pbma_pkg::status_t status;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [15:0] byte_addr;
    logic [3:0]  byte_count;
    logic [63:0] write_value;
    logic        done;
    logic [63:0] read_value;
    logic [1:0]  status;

    // Bench copy of the memory state
    bit [7:0]    mem_image [SpaceSize];
    bit          page_written [PageCount];

    access_t     access_queue [$];
    outcome_t    expected_results [$];
    bit [7:0]    hot_pages [NumHot];
    access_t     last_write;
    bit          have_last_write = 1'b0;
    bit          taken = 1'b0;
    int          gap_left = 0;
    int          n_total = 0;
    int          n_issued = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_failed = 0;
    int          status_seen [4] = '{0, 0, 0, 0};

    paged_byte_memory_access_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .byte_addr   (byte_addr),
        .byte_count  (byte_count),
        .write_value (write_value),
        .done        (done),
        .read_value  (read_value),
        .status      (status)
    );

    // Clock: 4 ns period
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Work out the result of one transaction and update the byte image
    function automatic outcome_t predict_memory_access(access_t a);
        outcome_t r;
        bit       unmapped;
        int       top;
        r.rdata  = '0;
        r.status = pbma_pkg::ST_OK;
        unmapped = 1'b0;
        top      = int'(a.addr) + int'(a.count);
        if (a.count == 0)
            r.status = pbma_pkg::ST_ZERO_LEN;
        else if (int'(a.count) > pbma_pkg::MaxBytes || top > SpaceSize)
            r.status = pbma_pkg::ST_RANGE;
        else if (a.cmd == CMD_WRITE)
        begin
            for (int k = 0; k < int'(a.count); k++)
            begin
                mem_image[int'(a.addr) + k] = a.wdata[8*k +: 8];
                page_written[(int'(a.addr) + k) >> PageShift] = 1'b1;
            end
        end
        else
        begin
            for (int k = 0; k < int'(a.count); k++)
                if (!page_written[(int'(a.addr) + k) >> PageShift])
                    unmapped = 1'b1;
            if (unmapped)
                r.status = pbma_pkg::ST_UNALLOC;
            else
                for (int k = 0; k < int'(a.count); k++)
                    r.rdata[8*k +: 8] = mem_image[int'(a.addr) + k];
        end
        return r;
    endfunction

    task automatic add_access(bit c, bit [15:0] a, bit [3:0] n, bit [63:0] w);
        access_t t;
        t.cmd   = c;
        t.addr  = a;
        t.count = n;
        t.wdata = w;
        access_queue.push_back(t);
    endtask

    // Mostly well-formed accesses to a few hot pages, read-backs, and some noise
    function automatic access_t make_random_access();
        access_t a;
        int      pick;
        bit [7:0] offs;
        a.wdata = {$urandom, $urandom};
        a.cmd   = 1'($urandom_range(0, 1));
        a.count = 4'($urandom_range(1, pbma_pkg::MaxBytes));
        a.addr  = 16'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // bad length, or an address at the top that the range may run past
            case ($urandom_range(0, 2))
                0: a.count = 4'd0;
                1: a.count = 4'($urandom_range(pbma_pkg::MaxBytes + 1, 15));
                default: a.addr = 16'hFFFF - 16'($urandom_range(0, 7));
            endcase
        end
        else if (pick < 30 && have_last_write)
        begin
            a.cmd   = CMD_READ;
            a.addr  = last_write.addr;
            a.count = last_write.count;
        end
        else if (pick < 85)
        begin
            offs = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                offs = 8'(256 - $urandom_range(1, 8));
            a.addr = {hot_pages[$urandom_range(0, NumHot - 1)], offs};
            if (a.cmd == CMD_WRITE)
            begin
                last_write      = a;
                have_last_write = 1'b1;
            end
        end
        return a;
    endfunction

    // Driver: present transactions at the falling edge, hold start until taken
    always @(negedge clk)
    begin
        access_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !taken)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (access_queue.size() == 0)
            start <= 1'b0;
        else if (n_issued < n_total - CalmTail && (n_issued / 200) % 3 != 2
                 && $urandom_range(0, 3) == 0)
        begin
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 9);
        end
        else
        begin
            nxt = access_queue.pop_front();
            start       <= 1'b1;
            cmd         <= nxt.cmd;
            byte_addr   <= nxt.addr;
            byte_count  <= nxt.count;
            write_value <= nxt.wdata;
            n_issued++;
        end
    end

    // Monitor: check each result, then record any transaction taken at this edge
    always @(posedge clk)
    begin
        outcome_t want;
        access_t  cur;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, read_value %h status %0d",
                             $time, read_value, status);
                    n_failed++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (read_value !== want.rdata)
                    begin
                        $display("%0t: read_value mismatch, expected %h actual %h",
                                 $time, want.rdata, read_value);
                        n_failed++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, status);
                        n_failed++;
                    end
                end
            end
            if (start && !busy)
            begin
                cur.cmd   = cmd;
                cur.addr  = byte_addr;
                cur.count = byte_count;
                cur.wdata = write_value;
                want = predict_memory_access(cur);
                expected_results.push_back(want);
                status_seen[want.status]++;
                n_accepted++;
            end
            taken <= start && !busy;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = 1'b0;
        byte_addr   = '0;
        byte_count  = '0;
        write_value = '0;

        hot_pages[0] = 8'h00;
        hot_pages[1] = 8'hFF;
        for (int i = 2; i < NumHot; i++)
            hot_pages[i] = 8'($urandom);

        // unallocated read, zero length, bad lengths, range past the top
        add_access(CMD_READ,  16'h0000, 4'd1,  64'h0);
        add_access(CMD_READ,  16'h0000, 4'd0,  64'h0);
        add_access(CMD_WRITE, 16'h0500, 4'd0,  '1);
        add_access(CMD_WRITE, 16'h0600, 4'd9,  '1);
        add_access(CMD_READ,  16'h00FC, 4'd15, 64'h0);
        add_access(CMD_WRITE, 16'hFFFE, 4'd8,  '1);
        // failed writes must not allocate
        add_access(CMD_READ,  16'h0500, 4'd1,  64'h0);
        add_access(CMD_READ,  16'h0600, 4'd8,  64'h0);
        add_access(CMD_READ,  16'hFFFE, 4'd2,  64'h0);
        // top of the address space
        add_access(CMD_WRITE, 16'hFFF8, 4'd8,  '1);
        add_access(CMD_READ,  16'hFFF8, 4'd8,  64'h0);
        add_access(CMD_READ,  16'hFFFF, 4'd1,  64'h0);
        add_access(CMD_READ,  16'hFFFF, 4'd2,  64'h0);
        // accesses across a page boundary; fresh page reads as zeros
        add_access(CMD_WRITE, 16'h00FC, 4'd8,  64'h0123_4567_89AB_CDEF);
        add_access(CMD_READ,  16'h00FC, 4'd8,  64'h0);
        add_access(CMD_READ,  16'h00FD, 4'd3,  64'h0);
        add_access(CMD_READ,  16'h0100, 4'd8,  64'h0);
        add_access(CMD_WRITE, 16'h02FE, 4'd2,  64'hFFFF_FFFF_FFFF_BEEF);
        add_access(CMD_READ,  16'h02FC, 4'd8,  64'h0);
        add_access(CMD_READ,  16'h02F8, 4'd8,  64'h0);
        add_access(CMD_WRITE, 16'h1234, 4'd1,  64'h0);
        add_access(CMD_READ,  16'h1200, 4'd8,  64'h0);
        add_access(CMD_WRITE, 16'h8000, 4'd4,  64'h5A5A_5A5A_A5A5_A5A5);
        add_access(CMD_READ,  16'h8000, 4'd8,  64'h0);

        for (int i = 0; i < NumRandom; i++)
            access_queue.push_back(make_random_access());
        n_total = access_queue.size();

        // hold reset, then release it away from the rising edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_accepted < n_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Ran %0d transactions, %0d results checked, %0d mismatches",
                 n_accepted, n_checked, n_failed);
        $display("Status mix: %0d ok, %0d zero length, %0d out of range, %0d unallocated",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_failed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: covers the clearing sweep after reset with a wide margin
    initial
    begin
        #2_000_000;
        $display("%0t: timeout, %0d of %0d transactions taken, %0d results outstanding",
                 $time, n_accepted, n_total, expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== paged_byte_memory_access_core.f =====
+incdir+rtl/core
rtl/core/pbma_pkg.sv
rtl/core/paged_byte_memory_access_core.sv
dv/tb_top.sv
